// ===== rtl/core/kpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Key press event detector package
// Shared types, widths, register indexes and event bits.
// ----------------------------------------------------------------------------
`default_nettype none

package kpe_pkg;

	localparam int KEY_BITS       = 8;
	localparam int TIMER_BITS_DEF = 16;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int EV_W           = 4;

	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT      = 2'd2;

	localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd100;
	localparam logic [CFG_W-1:0] SHORT_PRESS_RST = 16'd3;
	localparam logic [CFG_W-1:0] REPEAT_RST      = 16'd20;

	localparam logic [EV_W-1:0] EV_LONG    = 4'b0001;
	localparam logic [EV_W-1:0] EV_SHORT   = 4'b0010;
	localparam logic [EV_W-1:0] EV_REPEAT  = 4'b0100;
	localparam logic [EV_W-1:0] EV_RELEASE = 4'b1000;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                cmd;
		logic [KEY_BITS-1:0] key_sample;
		logic [KEY_BITS-1:0] query_key;
		logic [EV_W-1:0]     query_mask;
	} in_item_t;

	typedef struct packed {
		logic                query_hit;
		logic [EV_W-1:0]     pending_events;
		logic [KEY_BITS-1:0] event_key;
	} out_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] long_press_ticks;
		logic [CFG_W-1:0] short_press_ticks;
		logic [CFG_W-1:0] repeat_ticks;
	} cfg_regs_t;

endpackage

`default_nettype wire

// ===== rtl/core/kpe_cfg.sv =====
// ----------------------------------------------------------------------------
// Key press event detector configuration registers
// Holds the three timing thresholds written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module kpe_cfg
	import kpe_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output cfg_regs_t                 regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.long_press_ticks  <= LONG_PRESS_RST;
			regs_q.short_press_ticks <= SHORT_PRESS_RST;
			regs_q.repeat_ticks      <= REPEAT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_PRESS:  regs_q.long_press_ticks  <= cfg_data;
				REG_SHORT_PRESS: regs_q.short_press_ticks <= cfg_data;
				REG_REPEAT:      regs_q.repeat_ticks      <= cfg_data;
				default:         regs_q                   <= regs_q;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

// ===== rtl/core/kpe_fsm.sv =====
// ----------------------------------------------------------------------------
// Key press event detector state machine
// Holds the press state and event flags and computes one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module kpe_fsm
	import kpe_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire in_item_t  item,
	input  wire cfg_regs_t cfg,
	output out_item_t      result
);

	localparam int CmpW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SETTLE,
		PH_HELD,
		PH_WAIT
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d, bump;
	logic [KEY_BITS-1:0]   prev_q, key_q, key_d;
	logic [EV_W-1:0]       flags_q, flags_d;
	logic                  hit;
	logic [CmpW-1:0]       bump_c;

	assign bump   = (timer_q == '1) ? timer_q : timer_q + TIMER_BITS'(1);
	assign bump_c = CmpW'(bump);

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		key_d   = key_q;
		flags_d = flags_q;
		hit     = 1'b0;
		if (item.cmd == CMD_TICK) begin
			case (phase_q)
				PH_IDLE: begin
					timer_d = '0;
					flags_d = '0;
					if (item.key_sample != '0) begin
						phase_d = PH_SETTLE;
					end
				end
				PH_SETTLE: begin
					phase_d = PH_HELD;
				end
				PH_HELD: begin
					timer_d = bump;
					if (item.key_sample == prev_q) begin
						if (bump_c >= CmpW'(cfg.long_press_ticks)) begin
							flags_d = flags_q | EV_LONG;
							key_d   = prev_q;
							phase_d = PH_WAIT;
						end
					end else if (item.key_sample == '0) begin
						if (bump_c >= CmpW'(cfg.short_press_ticks)) begin
							flags_d = flags_q | EV_SHORT;
							key_d   = prev_q;
						end
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_WAIT: begin
					if (item.key_sample == prev_q) begin
						if (bump_c >= CmpW'(cfg.repeat_ticks)) begin
							flags_d = flags_q | EV_REPEAT;
							key_d   = prev_q;
							timer_d = '0;
						end else begin
							timer_d = bump;
						end
					end else if (item.key_sample == '0) begin
						flags_d = flags_q | EV_RELEASE;
						key_d   = prev_q;
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end else begin
			if (key_q == item.query_key && (flags_q & item.query_mask) != '0) begin
				flags_d = '0;
				hit     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			prev_q  <= '0;
			flags_q <= '0;
			key_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			flags_q <= flags_d;
			key_q   <= key_d;
			if (item.cmd == CMD_TICK) begin
				prev_q <= item.key_sample;
			end
		end
	end

	assign result.query_hit      = hit;
	assign result.pending_events = flags_d;
	assign result.event_key      = key_d;

endmodule

`default_nettype wire

// ===== rtl/core/key_press_event_detector.sv =====
// ----------------------------------------------------------------------------
// Key press event detector
// Tracks short, long, repeat and release events of a sampled key mask.
// ----------------------------------------------------------------------------
// The block accepts one beat per clock cycle while the input is not stalled
// and returns exactly one result beat for each input beat. An input register
// feeds the combinational state update, whose result lands in an output
// register; the state loop in the state machine sets the rate. A stalled
// output holds the result and the input register, and the input stalls only
// when both are occupied.
`default_nettype none

module key_press_event_detector
	import kpe_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data
);

	cfg_regs_t cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result, result_s2;
	logic      valid_s2;
	logic      s2_ready, in_fire, s1_fire;

	assign s2_ready = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !s2_ready;
	assign in_fire  = in_valid && !in_stall;
	assign s1_fire  = valid_s1 && s2_ready;

	kpe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (cfg)
	);

	kpe_fsm #(
		.TIMER_BITS (TIMER_BITS)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_data;
		end
		if (s1_fire) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

`default_nettype wire

// ===== rtl/core/kpe_checker.sv =====
// ----------------------------------------------------------------------------
// Key press event detector checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kpe_checker
	import kpe_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data
);

	// The input is held back only while a result is waiting on a stalled output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output free");

	// A query hit clears the pending flags in the same beat.
	a_hit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.query_hit) |-> (out_data.pending_events == '0))
		else $error("hit beat shows pending events");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result beat changed");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result beat dropped without handshake");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> (in_valid && $stable(in_data)))
		else $error("stalled input beat changed");

endmodule

bind key_press_event_detector kpe_checker u_kpe_checker (.*);

`default_nettype wire
